>>> design/rounded_box_border_overlay_top_defines.svh
// ----------------------------------------------------------------------------
// rounded box border overlay - assertion macros
// shared property wrappers for the port checker
// ----------------------------------------------------------------------------
`ifndef ROUNDED_BOX_BORDER_OVERLAY_TOP_DEFINES_SVH
`define ROUNDED_BOX_BORDER_OVERLAY_TOP_DEFINES_SVH

// same-cycle implication, off while in reset
`define RBBO_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("rbbo check failed");

// next-cycle implication, off while in reset
`define RBBO_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("rbbo check failed");

// next-cycle consequence of an asserted reset
`define RBBO_ASSERT_RESET(label, cons) \
    label: assert property (@(posedge aclk) !aresetn |=> (cons)) \
        else $error("rbbo reset check failed");

`endif

>>> design/rbbo_pkg.sv
// ----------------------------------------------------------------------------
// rbbo_pkg
// types and constants of the rounded box border overlay
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rbbo_pkg;

    localparam int LANES   = 4;
    localparam int GEO_W   = 16;   // signed box-relative coordinates
    localparam int DIST_W  = 10;   // corner distance 1..radius
    localparam int SQ_W    = 20;
    localparam int CFG_DW  = 24;
    localparam int CFG_AW  = 3;

    // register indexes
    localparam logic [CFG_AW-1:0] REG_BORDER_ENABLE    = 3'd0;
    localparam logic [CFG_AW-1:0] REG_BOX_X            = 3'd1;
    localparam logic [CFG_AW-1:0] REG_BOX_Y            = 3'd2;
    localparam logic [CFG_AW-1:0] REG_BOX_W            = 3'd3;
    localparam logic [CFG_AW-1:0] REG_BOX_H            = 3'd4;
    localparam logic [CFG_AW-1:0] REG_CORNER_RADIUS    = 3'd5;
    localparam logic [CFG_AW-1:0] REG_BORDER_THICKNESS = 3'd6;
    localparam logic [CFG_AW-1:0] REG_BORDER_COLOR     = 3'd7;

    localparam logic [7:0] BLACK_LUMA   = 8'd16;
    localparam logic [7:0] BLACK_CHROMA = 8'd128;

    typedef logic [1:0] pix_class_t;
    localparam pix_class_t CLS_NONE   = 2'd0;
    localparam pix_class_t CLS_MASK   = 2'd1;
    localparam pix_class_t CLS_BORDER = 2'd2;

    typedef struct packed {
        logic [10:0] quad_col;
        logic [10:0] quad_row;
        logic [7:0]  luma_top_left;
        logic [7:0]  luma_top_right;
        logic [7:0]  luma_bottom_left;
        logic [7:0]  luma_bottom_right;
        logic [7:0]  chroma_u;
        logic [7:0]  chroma_v;
    } quad_in_t;

    typedef struct packed {
        logic [7:0] new_luma_top_left;
        logic [7:0] new_luma_top_right;
        logic [7:0] new_luma_bottom_left;
        logic [7:0] new_luma_bottom_right;
        logic [7:0] new_chroma_u;
        logic [7:0] new_chroma_v;
    } quad_out_t;

    typedef struct packed {
        logic        border_enable;
        logic [11:0] box_x;
        logic [11:0] box_y;
        logic [12:0] box_w;
        logic [12:0] box_h;
        logic [9:0]  corner_radius;
        logic [9:0]  border_thickness;
        logic [23:0] border_color;
    } cfg_t;

    // corner limits shared by all lanes, one stage behind the geometry
    typedef struct packed {
        logic [SQ_W-1:0] rr;
        logic [SQ_W-1:0] inner;
        logic            thick_nz;
    } limits_t;

endpackage

>>> design/rbbo_lane.sv
// ----------------------------------------------------------------------------
// rbbo_lane
// classifies one luma pixel against the rounded box: geometry, squares, compare
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rbbo_lane #(
    parameter int CANVAS_WIDTH  = 4096,
    parameter int CANVAS_HEIGHT = 4096
) (
    input  logic                aclk,
    input  logic                st1_en,
    input  logic                st2_en,
    input  logic [11:0]         px,
    input  logic [11:0]         py,
    input  rbbo_pkg::cfg_t      cfg,
    input  rbbo_pkg::limits_t   lim,
    output rbbo_pkg::pix_class_t pix_class
);

    localparam int GW = rbbo_pkg::GEO_W;
    localparam int DW = rbbo_pkg::DIST_W;
    localparam int SW = rbbo_pkg::SQ_W;

    // box geometry
    logic [12:0]          ox, oy;
    logic [13:0]          w, h;
    logic signed [GW-1:0] lx, ly, r_s, t_s, w_s, h_s, wr, hr, wt, ht;
    logic signed [GW-1:0] dx0_full, dx1_full, dy0_full, dy1_full;
    logic                 band_x, band_y;

    assign ox  = 13'({1'b0, cfg.box_x} + 13'd1) & 13'h1FFE;
    assign oy  = 13'({1'b0, cfg.box_y} + 13'd1) & 13'h1FFE;
    assign w   = 14'({1'b0, cfg.box_w} + 14'd1) & 14'h3FFE;
    assign h   = 14'({1'b0, cfg.box_h} + 14'd1) & 14'h3FFE;

    assign r_s = $signed({{(GW-10){1'b0}}, cfg.corner_radius});
    assign t_s = $signed({{(GW-10){1'b0}}, cfg.border_thickness});
    assign w_s = $signed({{(GW-14){1'b0}}, w});
    assign h_s = $signed({{(GW-14){1'b0}}, h});
    assign lx  = $signed({{(GW-12){1'b0}}, px}) - $signed({{(GW-13){1'b0}}, ox});
    assign ly  = $signed({{(GW-12){1'b0}}, py}) - $signed({{(GW-13){1'b0}}, oy});
    assign wr  = w_s - r_s;
    assign hr  = h_s - r_s;
    assign wt  = w_s - t_s;
    assign ht  = h_s - t_s;

    assign dx0_full = r_s - lx;
    assign dx1_full = lx - wr + 16'sd1;
    assign dy0_full = r_s - ly;
    assign dy1_full = ly - hr + 16'sd1;

    // straight edge bands between the corner squares
    assign band_x = (lx >= r_s) && (lx < wr) &&
                    (((ly >= 16'sd0) && (ly < t_s)) || ((ly >= ht) && (ly < h_s)));
    assign band_y = (ly >= r_s) && (ly < hr) &&
                    (((lx >= 16'sd0) && (lx < t_s)) || ((lx >= wt) && (lx < w_s)));

    // stage 1: geometry
    logic [1:0]    hx_reg, hx_next, hy_reg, hy_next;
    logic [DW-1:0] dx_reg [2];
    logic [DW-1:0] dy_reg [2];
    logic [DW-1:0] dx_next [2];
    logic [DW-1:0] dy_next [2];
    logic          edge_band_reg, edge_band_next;
    logic          on_canvas_reg, on_canvas_next;

    always_comb begin
        hx_next[0]     = (lx >= 16'sd0) && (lx < r_s);
        hx_next[1]     = (lx >= wr) && (lx < w_s);
        hy_next[0]     = (ly >= 16'sd0) && (ly < r_s);
        hy_next[1]     = (ly >= hr) && (ly < h_s);
        dx_next[0]     = dx0_full[DW-1:0];
        dx_next[1]     = dx1_full[DW-1:0];
        dy_next[0]     = dy0_full[DW-1:0];
        dy_next[1]     = dy1_full[DW-1:0];
        edge_band_next = (cfg.border_thickness != 10'd0) && (band_x || band_y);
        on_canvas_next = ({2'b00, px} < 14'(CANVAS_WIDTH)) &&
                         ({2'b00, py} < 14'(CANVAS_HEIGHT));
    end

    always_ff @(posedge aclk) begin
        if (st1_en) begin
            hx_reg        <= hx_next;
            hy_reg        <= hy_next;
            dx_reg        <= dx_next;
            dy_reg        <= dy_next;
            edge_band_reg <= edge_band_next;
            on_canvas_reg <= on_canvas_next;
        end
    end

    // stage 2: squared distances
    logic [SW-1:0] sqx_reg [2];
    logic [SW-1:0] sqy_reg [2];
    logic [SW-1:0] sqx_next [2];
    logic [SW-1:0] sqy_next [2];
    logic [1:0]    hx2_reg, hy2_reg;
    logic          edge2_reg, canvas2_reg;

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            sqx_next[k] = SW'(dx_reg[k]) * SW'(dx_reg[k]);
            sqy_next[k] = SW'(dy_reg[k]) * SW'(dy_reg[k]);
        end
    end

    always_ff @(posedge aclk) begin
        if (st2_en) begin
            sqx_reg     <= sqx_next;
            sqy_reg     <= sqy_next;
            hx2_reg     <= hx_reg;
            hy2_reg     <= hy_reg;
            edge2_reg   <= edge_band_reg;
            canvas2_reg <= on_canvas_reg;
        end
    end

    // corner compare over the four corner squares
    logic mask_hit, arc_hit;

    always_comb begin
        logic [SW:0] d2;
        logic        hit;
        mask_hit = 1'b0;
        arc_hit  = 1'b0;
        for (int a = 0; a < 2; a++) begin
            for (int b = 0; b < 2; b++) begin
                d2  = {1'b0, sqx_reg[a]} + {1'b0, sqy_reg[b]};
                hit = hx2_reg[a] && hy2_reg[b];
                if (hit && (d2 > {1'b0, lim.rr})) begin
                    mask_hit = 1'b1;
                end else if (hit && lim.thick_nz && (d2 > {1'b0, lim.inner})) begin
                    arc_hit = 1'b1;
                end
            end
        end
        if (!canvas2_reg) begin
            pix_class = rbbo_pkg::CLS_NONE;
        end else if (arc_hit || edge2_reg) begin
            pix_class = rbbo_pkg::CLS_BORDER;
        end else if (mask_hit) begin
            pix_class = rbbo_pkg::CLS_MASK;
        end else begin
            pix_class = rbbo_pkg::CLS_NONE;
        end
    end

endmodule

>>> design/rbbo_merge.sv
// ----------------------------------------------------------------------------
// rbbo_merge
// combines the four lane classes into new luma and shared chroma
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rbbo_merge (
    input  logic                                         active,
    input  logic [23:0]                                  border_color,
    input  rbbo_pkg::pix_class_t [rbbo_pkg::LANES-1:0]   cls,
    input  rbbo_pkg::quad_in_t                           quad,
    output rbbo_pkg::quad_out_t                          result
);

    logic [7:0] luma_in  [rbbo_pkg::LANES];
    logic [7:0] luma_out [rbbo_pkg::LANES];
    logic       any_border, any_mask;

    assign luma_in[0] = quad.luma_top_left;
    assign luma_in[1] = quad.luma_top_right;
    assign luma_in[2] = quad.luma_bottom_left;
    assign luma_in[3] = quad.luma_bottom_right;

    always_comb begin
        any_border = 1'b0;
        any_mask   = 1'b0;
        for (int i = 0; i < rbbo_pkg::LANES; i++) begin
            luma_out[i] = luma_in[i];
            if (active) begin
                case (cls[i])
                    rbbo_pkg::CLS_BORDER: begin
                        luma_out[i] = border_color[23:16];
                        any_border  = 1'b1;
                    end
                    rbbo_pkg::CLS_MASK: begin
                        luma_out[i] = rbbo_pkg::BLACK_LUMA;
                        any_mask    = 1'b1;
                    end
                    default: begin
                        luma_out[i] = luma_in[i];
                    end
                endcase
            end
        end

        result.new_luma_top_left     = luma_out[0];
        result.new_luma_top_right    = luma_out[1];
        result.new_luma_bottom_left  = luma_out[2];
        result.new_luma_bottom_right = luma_out[3];
        if (any_border) begin
            result.new_chroma_u = border_color[15:8];
            result.new_chroma_v = border_color[7:0];
        end else if (any_mask) begin
            result.new_chroma_u = rbbo_pkg::BLACK_CHROMA;
            result.new_chroma_v = rbbo_pkg::BLACK_CHROMA;
        end else begin
            result.new_chroma_u = quad.chroma_u;
            result.new_chroma_v = quad.chroma_v;
        end
    end

endmodule

>>> design/rounded_box_border_overlay_top.sv
// ----------------------------------------------------------------------------
// rounded_box_border_overlay_top
// rounded box corner mask and border overlay for one nv12 2x2 quad per transfer
// ----------------------------------------------------------------------------
// an input transfer passes the geometry and squaring registers, then the merge
// into the output register, before m_valid offers its result
// throughput: one quad per cycle unless the output stalls, four pixel lanes
// side by side; the three-stage pipeline holds one quad per stage, and a
// stalled output lets empty stages upstream keep filling
// reset: synchronous active-low aresetn empties the pipeline and loads
// register defaults (box size 2, everything else 0)
`timescale 1ns / 1ps

module rounded_box_border_overlay_top #(
    parameter int CANVAS_WIDTH  = 4096,
    parameter int CANVAS_HEIGHT = 4096
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            cfg_we,
    input  logic [rbbo_pkg::CFG_AW-1:0]     cfg_addr,
    input  logic [rbbo_pkg::CFG_DW-1:0]     cfg_wdata,

    input  logic                            s_valid,
    output logic                            s_ready,
    input  rbbo_pkg::quad_in_t              s_data,

    output logic                            m_valid,
    input  logic                            m_ready,
    output rbbo_pkg::quad_out_t             m_data
);

    // configuration registers
    rbbo_pkg::cfg_t cfg_reg, cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_addr)
                rbbo_pkg::REG_BORDER_ENABLE:    cfg_next.border_enable    = cfg_wdata[0];
                rbbo_pkg::REG_BOX_X:            cfg_next.box_x            = cfg_wdata[11:0];
                rbbo_pkg::REG_BOX_Y:            cfg_next.box_y            = cfg_wdata[11:0];
                rbbo_pkg::REG_BOX_W:            cfg_next.box_w            = cfg_wdata[12:0];
                rbbo_pkg::REG_BOX_H:            cfg_next.box_h            = cfg_wdata[12:0];
                rbbo_pkg::REG_CORNER_RADIUS:    cfg_next.corner_radius    = cfg_wdata[9:0];
                rbbo_pkg::REG_BORDER_THICKNESS: cfg_next.border_thickness = cfg_wdata[9:0];
                rbbo_pkg::REG_BORDER_COLOR:     cfg_next.border_color     = cfg_wdata[23:0];
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            // enable, x, y, w, h, radius, thickness, color
            cfg_reg <= {1'b0, 12'd0, 12'd0, 13'd2, 13'd2, 10'd0, 10'd0, 24'd0};
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // pipeline control
    logic v1_reg, v1_next, v2_reg, v2_next, m_valid_reg, m_valid_next;
    logic ready2, ready3, st1_en, st2_en, st3_en;

    assign ready3  = !m_valid_reg || m_ready;
    assign ready2  = !v2_reg || ready3;
    assign s_ready = !v1_reg || ready2;
    assign st1_en  = s_valid && s_ready;
    assign st2_en  = v1_reg && ready2;
    assign st3_en  = v2_reg && ready3;

    always_comb begin
        v1_next      = st1_en ? 1'b1 : (st2_en ? 1'b0 : v1_reg);
        v2_next      = st2_en ? 1'b1 : (st3_en ? 1'b0 : v2_reg);
        m_valid_next = st3_en ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            v1_reg      <= v1_next;
            v2_reg      <= v2_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload carried alongside the lanes
    rbbo_pkg::quad_in_t quad1_reg, quad2_reg;

    always_ff @(posedge aclk) begin
        if (st1_en) begin
            quad1_reg <= s_data;
        end
        if (st2_en) begin
            quad2_reg <= quad1_reg;
        end
    end

    // corner limits, squared in stage 2 next to the lane squares
    rbbo_pkg::limits_t lim_reg, lim_next;
    logic signed [10:0] r_minus_t;
    logic [9:0]         r_minus_t_abs;

    assign r_minus_t     = $signed({1'b0, cfg_reg.corner_radius}) -
                           $signed({1'b0, cfg_reg.border_thickness});
    assign r_minus_t_abs = r_minus_t[10] ? 10'(-r_minus_t) : r_minus_t[9:0];

    always_comb begin
        lim_next.rr       = rbbo_pkg::SQ_W'(cfg_reg.corner_radius) *
                            rbbo_pkg::SQ_W'(cfg_reg.corner_radius);
        lim_next.inner    = rbbo_pkg::SQ_W'(r_minus_t_abs) *
                            rbbo_pkg::SQ_W'(r_minus_t_abs);
        lim_next.thick_nz = cfg_reg.border_thickness != 10'd0;
    end

    always_ff @(posedge aclk) begin
        if (st2_en) begin
            lim_reg <= lim_next;
        end
    end

    // pixel lanes: lane bit 0 picks the odd column, bit 1 the odd row
    rbbo_pkg::pix_class_t [rbbo_pkg::LANES-1:0] lane_class;

    for (genvar i = 0; i < rbbo_pkg::LANES; i++) begin : g_lane
        rbbo_lane #(
            .CANVAS_WIDTH  (CANVAS_WIDTH),
            .CANVAS_HEIGHT (CANVAS_HEIGHT)
        ) u_lane (
            .aclk      (aclk),
            .st1_en    (st1_en),
            .st2_en    (st2_en),
            .px        ({s_data.quad_col, 1'(i % 2)}),
            .py        ({s_data.quad_row, 1'(i / 2)}),
            .cfg       (cfg_reg),
            .lim       (lim_reg),
            .pix_class (lane_class[i])
        );
    end

    // merge and output register
    rbbo_pkg::quad_out_t merged, m_data_reg, m_data_next;
    logic                active;

    assign active = cfg_reg.border_enable && (cfg_reg.corner_radius != 10'd0);

    rbbo_merge u_merge (
        .active       (active),
        .border_color (cfg_reg.border_color),
        .cls          (lane_class),
        .quad         (quad2_reg),
        .result       (merged)
    );

    assign m_data_next = st3_en ? merged : m_data_reg;

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

>>> design/rbbo_checker.sv
// ----------------------------------------------------------------------------
// rbbo_checker
// port-level checks of the rounded box border overlay, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "rounded_box_border_overlay_top_defines.svh"

module rbbo_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input rbbo_pkg::quad_out_t m_data
);

    // a result not taken stays put
    `RBBO_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data))

    // an offered input transfer is not withdrawn
    `RBBO_ASSERT_NEXT(a_in_hold, s_valid && !s_ready, s_valid)

    // an empty output means the whole pipeline can take a transfer
    `RBBO_ASSERT_SAME(a_ready_when_empty, !m_valid, s_ready)

    // reset clears the output valid
    `RBBO_ASSERT_RESET(a_reset_flush, !m_valid)

endmodule

bind rounded_box_border_overlay_top rbbo_checker u_rbbo_checker (.*);
